[rtl/rkl_pkg.sv]
// Shared types and constants for the ASCII record key lookup block.
// Used by rkl_scan, rkl_out_reg and ascii_record_key_lookup; no dependencies.
package rkl_pkg;

    // Bytes that bound the ASCII digit range (exclusive)
    localparam logic [7:0]  DIGIT_BELOW = 8'h2F;
    localparam logic [7:0]  DIGIT_ABOVE = 8'h3A;

    // A third run keeps at most this many digits and is forced to zero if it has more
    localparam logic [3:0]  THIRD_KEEP  = 4'd9;
    localparam logic [3:0]  THIRD_LONG  = 4'd10;

    // Number of digit runs that are tracked per record
    localparam logic [1:0]  RUN_COUNT   = 2'd3;
    localparam logic [1:0]  RUN_FIRST   = 2'd0;
    localparam logic [1:0]  RUN_SECOND  = 2'd1;
    localparam logic [1:0]  RUN_THIRD   = 2'd2;

    localparam logic [15:0] BYTE_MASK   = 16'h00FF;

    localparam int VALUE_W = 16;
    localparam int THIRD_W = 30;
    localparam int KEY_W   = 32;
    localparam int WORD_W  = 32;

    // Result handed from the scanner to the output register
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [WORD_W-1:0] word;
    } res_t;

    // Swap the two bytes of a 16-bit value
    function automatic logic [VALUE_W-1:0] swap16(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] hi;
        lo = (v & BYTE_MASK) << 8;
        hi = (v >> 8) & BYTE_MASK;
        return lo | hi;
    endfunction

endpackage

[rtl/rkl_scan.sv]
// Per-byte record scanner: digit run parsing, key compare and result build.
// Depends on rkl_pkg.
module rkl_scan #(
    parameter int RECORD_BYTES = 32,
    parameter int MAX_DIGITS   = 10
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       adv,        // process one byte this cycle
    input  logic [7:0]                 rec_byte,
    input  logic                       rec_last,
    input  logic [rkl_pkg::KEY_W-1:0]  key,
    output logic                       at_end,     // current byte closes the record
    output rkl_pkg::res_t              res
);

    localparam int POS_W = $clog2(RECORD_BYTES);

    logic [POS_W-1:0]              pos_reg,    pos_next;
    logic [1:0]                    field_reg,  field_next;
    logic [3:0]                    count_reg,  count_next;
    logic [rkl_pkg::VALUE_W-1:0]   first_reg,  first_next;
    logic [rkl_pkg::VALUE_W-1:0]   second_reg, second_next;
    logic [rkl_pkg::THIRD_W-1:0]   third_reg,  third_next;
    logic                          done_reg,   done_next;

    logic                          is_digit;
    logic                          active;
    logic [3:0]                    digit;
    logic [rkl_pkg::VALUE_W-1:0]   v1;
    logic [rkl_pkg::VALUE_W-1:0]   v2;
    logic [rkl_pkg::THIRD_W-1:0]   v3;
    logic                          match;

    assign at_end   = (pos_reg == POS_W'(RECORD_BYTES - 1));
    assign is_digit = (rec_byte > rkl_pkg::DIGIT_BELOW) && (rec_byte < rkl_pkg::DIGIT_ABOVE);
    assign active   = !done_reg && (field_reg < rkl_pkg::RUN_COUNT);
    assign digit    = rec_byte[3:0];

    // Update the run values for one byte
    always_comb begin
        field_next  = field_reg;
        count_next  = count_reg;
        first_next  = first_reg;
        second_next = second_reg;
        third_next  = third_reg;
        if (active) begin
            if (is_digit) begin
                if (count_reg < 4'(MAX_DIGITS)) begin
                    if (field_reg == rkl_pkg::RUN_FIRST) begin
                        first_next = rkl_pkg::VALUE_W'(first_reg * 16'd10
                                     + rkl_pkg::VALUE_W'(digit));
                    end else if (field_reg == rkl_pkg::RUN_SECOND) begin
                        second_next = rkl_pkg::VALUE_W'(second_reg * 16'd10
                                      + rkl_pkg::VALUE_W'(digit));
                    end else if (count_reg < rkl_pkg::THIRD_KEEP) begin
                        third_next = rkl_pkg::THIRD_W'(third_reg * 30'd10
                                     + rkl_pkg::THIRD_W'(digit));
                    end
                    count_next = count_reg + 4'd1;
                end
            end else if (count_reg != 4'd0) begin
                if (field_reg == rkl_pkg::RUN_THIRD && count_reg >= rkl_pkg::THIRD_LONG) begin
                    third_next = '0;
                end
                field_next = field_reg + 2'd1;
                count_next = 4'd0;
            end
        end
    end

    // Take only closed runs at the record end and compare the third with the key
    always_comb begin
        v1    = (field_next >= 2'd1) ? first_next  : '0;
        v2    = (field_next >= 2'd2) ? second_next : '0;
        v3    = (field_next >= rkl_pkg::RUN_COUNT) ? third_next : '0;
        match = ({2'b00, v3} == key);

        res.valid = adv && at_end && !done_reg && (match || rec_last);
        res.found = match;
        res.word  = match ? {rkl_pkg::swap16(v1), rkl_pkg::swap16(v2)} : '0;

        done_next = done_reg;
        if (at_end) begin
            done_next = rec_last ? 1'b0 : (done_reg || match);
        end
    end

    // Advance the record state on each processed byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            field_reg  <= '0;
            count_reg  <= '0;
            first_reg  <= '0;
            second_reg <= '0;
            third_reg  <= '0;
            done_reg   <= 1'b0;
        end else if (adv) begin
            done_reg <= done_next;
            if (at_end) begin
                pos_reg    <= '0;
                field_reg  <= '0;
                count_reg  <= '0;
                first_reg  <= '0;
                second_reg <= '0;
                third_reg  <= '0;
            end else begin
                pos_reg    <= pos_reg + POS_W'(1);
                field_reg  <= field_next;
                count_reg  <= count_next;
                first_reg  <= first_next;
                second_reg <= second_next;
                third_reg  <= third_next;
            end
        end
    end

endmodule

[rtl/rkl_out_reg.sv]
// Result output register of the record key lookup block.
// Depends on rkl_pkg.
module rkl_out_reg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rkl_pkg::res_t               res,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rkl_pkg::WORD_W-1:0]  m_tdata,
    output logic                        m_tuser
);

    logic                        valid_reg;
    logic                        found_reg;
    logic [rkl_pkg::WORD_W-1:0]  word_reg;

    // Hold a result until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res.valid) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Load payload with each new result
    always_ff @(posedge aclk) begin
        if (res.valid) begin
            found_reg <= res.found;
            word_reg  <= res.word;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = word_reg;
    assign m_tuser  = found_reg;

endmodule

[rtl/ascii_record_key_lookup.sv]
// Top level of the ASCII record key lookup: input register, scanner, result register.
// Depends on rkl_pkg, rkl_scan and rkl_out_reg.
//
//  Channel | Direction | Handshake          | Payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata[7:0] record_byte, s_tlast last_record
//  m_      | out       | m_tvalid/m_tready  | m_tdata[31:0] lookup_word, m_tuser found
//  cfg_    | in        | cfg_wr_en          | cfg_wr_data[31:0] search_key
//
// One byte is taken per cycle unless stalled as below; each byte passes the input
// register, then the scanner updates record state and builds any result into the
// output register.
// A result appears at most once per record; only a record's closing byte waits
// for a full output register to drain. Reset (aresetn low, synchronous) clears
// all control state and the key; no clearing pass.
module ascii_record_key_lookup #(
    parameter int RECORD_BYTES = 32,
    parameter int MAX_DIGITS   = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,     // [7:0] record_byte
    input  logic                        s_tlast,     // last_record
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rkl_pkg::WORD_W-1:0]  m_tdata,     // [31:0] lookup_word
    output logic                        m_tuser,     // found
    input  logic                        cfg_wr_en,
    input  logic [rkl_pkg::KEY_W-1:0]   cfg_wr_data  // search_key
);

    logic                        in_valid_reg;
    logic [7:0]                  in_byte_reg;
    logic                        in_last_reg;
    logic [rkl_pkg::KEY_W-1:0]   key_reg;
    logic                        at_end;
    logic                        adv;
    rkl_pkg::res_t               res;

    // Move a byte on unless it closes a record and the result slot is still full
    assign adv      = in_valid_reg && (!at_end || !m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || adv;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Search key register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cfg_wr_en) begin
            key_reg <= cfg_wr_data;
        end
    end

    rkl_scan #(
        .RECORD_BYTES (RECORD_BYTES),
        .MAX_DIGITS   (MAX_DIGITS)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .rec_byte (in_byte_reg),
        .rec_last (in_last_reg),
        .key      (key_reg),
        .at_end   (at_end),
        .res      (res)
    );

    rkl_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTH
    // A new result never lands on an undelivered one
    assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> (!m_tvalid || m_tready))
        else $error("result loaded while output register busy");

    // Results only come from a record's closing byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> (adv && at_end))
        else $error("result outside record end");

    // A no-match result carries a zero word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("nonzero word on not-found result");
`endif

endmodule
